>>> hdl/b64e_pkg.sv
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the alphabet mapping of the base64 stream
// encoder (alphabet ending in '+' and '_').
// ----------------------------------------------------------------------------
package b64e_pkg;

   localparam int BYTE_W     = 8;
   localparam int CHAR_W     = 7;
   localparam int SEXTET_W   = 6;
   localparam int CARRY_W    = 4;
   localparam int GROUP_MAX  = 4;
   localparam int GROUP_CNT_W = 3;

   // position within a group of three bytes
   typedef enum logic [2:0] {
      PHASE_0 = 3'b001,
      PHASE_1 = 3'b010,
      PHASE_2 = 3'b100
   } phase_type;

   localparam logic [CHAR_W-1:0] PAD_CHAR        = 7'h3D;
   localparam logic [CHAR_W-1:0] PLUS_CHAR       = 7'h2B;
   localparam logic [CHAR_W-1:0] UNDERSCORE_CHAR = 7'h5F;

   // characters produced by one request, slot 0 goes out first
   typedef struct packed {
      logic [GROUP_MAX-1:0][CHAR_W-1:0] chars;
      logic [GROUP_MAX-1:0]             lasts;
      logic [GROUP_CNT_W-1:0]           count;
      phase_type                        next_phase;
      logic [CARRY_W-1:0]               next_carry;
   } group_type;

   function automatic logic [CHAR_W-1:0] b64e_sym(input logic [SEXTET_W-1:0] v);
      logic [CHAR_W-1:0] c;
      logic [CHAR_W-1:0] w;
      w = {1'b0, v};
      if (v < 6'd26) begin
         c = 7'd65 + w;
      end else if (v < 6'd52) begin
         c = 7'd71 + w;
      end else if (v < 6'd62) begin
         c = w - 7'd4;
      end else if (v == 6'd62) begin
         c = PLUS_CHAR;
      end else begin
         c = UNDERSCORE_CHAR;
      end
      return c;
   endfunction

endpackage

>>> hdl/b64e_stream_if.sv
// ----------------------------------------------------------------------------
// b64e_stream_if
// Valid/ready channels of the base64 stream encoder: raw bytes in,
// encoded characters out.
// ----------------------------------------------------------------------------
interface b64e_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       final_byte;

   modport source (output valid, output data_byte, output final_byte, input ready);
   modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

interface b64e_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] out_char;
   logic       out_last;

   modport source (output valid, output out_char, output out_last, input ready);
   modport sink (input valid, input out_char, input out_last, output ready);
endinterface

>>> hdl/b64e_encode.sv
// ----------------------------------------------------------------------------
// b64e_encode
// Turns one byte plus the running phase and leftover bits into the group of
// one to four characters it produces, and the next phase and leftover bits.
// ----------------------------------------------------------------------------
module b64e_encode import b64e_pkg::*; (
   input  phase_type          phase,
   input  logic [CARRY_W-1:0] carry,
   input  logic [BYTE_W-1:0]  data_byte,
   input  logic               final_byte,
   output group_type          group
);

   always_comb begin
      group            = '0;
      group.next_phase = PHASE_0;
      group.next_carry = '0;
      case (phase)
         PHASE_1: begin
            group.chars[0] = b64e_sym({carry[1:0], data_byte[7:4]});
            if (final_byte) begin
               group.chars[1] = b64e_sym({data_byte[3:0], 2'b00});
               group.chars[2] = PAD_CHAR;
               group.lasts[2] = 1'b1;
               group.count    = 3'd3;
            end else begin
               group.count      = 3'd1;
               group.next_carry = data_byte[3:0];
               group.next_phase = PHASE_2;
            end
         end
         PHASE_2: begin
            group.chars[0] = b64e_sym({carry, data_byte[7:6]});
            group.chars[1] = b64e_sym(data_byte[5:0]);
            group.lasts[1] = final_byte;
            group.count    = 3'd2;
         end
         default: begin
            // unused phase code behaves as the start of a group
            group.chars[0] = b64e_sym(data_byte[7:2]);
            if (final_byte) begin
               group.chars[1] = b64e_sym({data_byte[1:0], 4'b0000});
               group.chars[2] = PAD_CHAR;
               group.chars[3] = PAD_CHAR;
               group.lasts[3] = 1'b1;
               group.count    = 3'd4;
            end else begin
               group.count      = 3'd1;
               group.next_carry = {2'b00, data_byte[1:0]};
               group.next_phase = PHASE_1;
            end
         end
      endcase
   end

endmodule

>>> hdl/base64_stream_encoder.sv
// Flow: an accepted byte's characters are loaded into the character buffer,
//   then moved one at a time through the single-character output register
//   to rsp; a stalled rsp holds them there. A byte yields 1, 1, 2 characters
//   in a group (4, 3 or 2 for the last byte of a message), and req takes the
//   next byte as the buffer hands its last character to the output register.
// Reset: synchronous, clears phase, leftover bits and all valid/count state.
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Streaming base64 encoder: one byte per request, one character per
// response, with '=' padding and a last marker at the end of a message.
// ----------------------------------------------------------------------------
module base64_stream_encoder import b64e_pkg::*; (
   input logic         clock,
   input logic         reset,
   b64e_req_if.sink    req,
   b64e_rsp_if.source  rsp
);

   phase_type                        phase_ff, phase_in;
   logic [CARRY_W-1:0]               carry_ff, carry_in;
   logic [GROUP_MAX-1:0][CHAR_W-1:0] chars_ff, chars_in;
   logic [GROUP_MAX-1:0]             lasts_ff, lasts_in;
   logic [GROUP_CNT_W-1:0]           count_ff, count_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]                rsp_char_ff, rsp_char_in;
   logic                             rsp_last_ff, rsp_last_in;

   group_type group;
   logic      move;
   logic      accept;

   b64e_encode u_encode (
      .phase      (phase_ff),
      .carry      (carry_ff),
      .data_byte  (req.data_byte),
      .final_byte (req.final_byte),
      .group      (group)
   );

   assign move      = (count_ff != '0) && (!rsp_valid_ff || rsp.ready);
   // take a new request when the buffer is empty or empties this cycle
   assign req.ready = (count_ff == '0) || (move && (count_ff == 3'd1));
   assign accept    = req.valid && req.ready;

   always_comb begin
      phase_in = phase_ff;
      carry_in = carry_ff;
      chars_in = chars_ff;
      lasts_in = lasts_ff;
      count_in = count_ff;
      if (move) begin
         for (int i = 0; i < GROUP_MAX - 1; i++) begin
            chars_in[i] = chars_ff[i+1];
            lasts_in[i] = lasts_ff[i+1];
         end
         chars_in[GROUP_MAX-1] = '0;
         lasts_in[GROUP_MAX-1] = 1'b0;
         count_in = count_ff - 3'd1;
      end
      if (accept) begin
         phase_in = group.next_phase;
         carry_in = group.next_carry;
         chars_in = group.chars;
         lasts_in = group.lasts;
         count_in = group.count;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      if (move) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = chars_ff[0];
         rsp_last_in  = lasts_ff[0];
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_0;
         carry_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         carry_ff     <= carry_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chars_ff    <= chars_in;
      lasts_ff    <= lasts_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.out_char = rsp_char_ff;
   assign rsp.out_last = rsp_last_ff;

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'd4)
      else $error("character buffer count out of range");

   a_phase_code: assert property (@(posedge clock) disable iff (reset)
      $onehot(phase_ff))
      else $error("unused phase code reached");

   a_final_restarts: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && req.final_byte) |=> (phase_ff == PHASE_0 && carry_ff == '0))
      else $error("phase not cleared after last byte");

   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> (count_ff != '0))
      else $error("request accepted without buffered characters");

   a_last_only_at_end: assert property (@(posedge clock) disable iff (reset)
      (move && lasts_ff[0]) |-> (count_ff == 3'd1))
      else $error("last marker before the end of the buffered group");
`endif

endmodule

>>> tb/base64_char_checker.sv
// ----------------------------------------------------------------------------
// base64_char_checker
// Watches the request and character channels of the base64 stream encoder,
// predicts the encoded characters of every accepted request and compares
// each accepted character, in order, against the prediction.
// ----------------------------------------------------------------------------
module base64_char_checker import b64e_pkg::*; (
   input  logic clock,
   input  logic reset,
   b64e_req_if  req,
   b64e_rsp_if  rsp,
   output int   mismatch_count,
   output int   chars_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [CHAR_W-1:0] code;
      logic              last;
   } enc_char_type;

   localparam logic [8*64-1:0] ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+_";

   enc_char_type       expected_chars[$];
   phase_type          grp_phase;
   logic [CARRY_W-1:0] carry;
   int                 errors_seen = 0;

   assign mismatch_count = errors_seen;

   // first alphabet character sits in the top byte of the literal
   function automatic logic [CHAR_W-1:0] sextet_char(input logic [5:0] s);
      int idx;
      idx = 63 - int'(s);
      return ALPHABET[idx*8 +: CHAR_W];
   endfunction

   function automatic void push_char(input logic [CHAR_W-1:0] c, input logic l);
      enc_char_type e;
      e.code = c;
      e.last = l;
      expected_chars.push_back(e);
   endfunction

   function automatic void encode_byte(input logic [7:0] b, input logic fin);
      case (grp_phase)
         PHASE_1: begin
            push_char(sextet_char({carry[1:0], b[7:4]}), 1'b0);
            if (fin) begin
               push_char(sextet_char({b[3:0], 2'b00}), 1'b0);
               push_char(PAD_CHAR, 1'b1);
               grp_phase = PHASE_0;
               carry = '0;
            end else begin
               carry = b[3:0];
               grp_phase = PHASE_2;
            end
         end
         PHASE_2: begin
            push_char(sextet_char({carry, b[7:6]}), 1'b0);
            push_char(sextet_char(b[5:0]), fin);
            grp_phase = PHASE_0;
            carry = '0;
         end
         default: begin
            push_char(sextet_char(b[7:2]), 1'b0);
            if (fin) begin
               push_char(sextet_char({b[1:0], 4'b0000}), 1'b0);
               push_char(PAD_CHAR, 1'b0);
               push_char(PAD_CHAR, 1'b1);
               grp_phase = PHASE_0;
               carry = '0;
            end else begin
               carry = {2'b00, b[1:0]};
               grp_phase = PHASE_1;
            end
         end
      endcase
   endfunction

   always @(posedge clock) begin
      enc_char_type want;
      if (reset) begin
         expected_chars.delete();
         grp_phase = PHASE_0;
         carry = '0;
      end else begin
         // a request's characters reach rsp only after the character buffer and output register
         if (rsp.valid && rsp.ready) begin
            if (expected_chars.size() == 0) begin
               $display("%0t: unexpected char: expected none, actual char=%h last=%b",
                        $time, rsp.out_char, rsp.out_last);
               errors_seen++;
            end else begin
               want = expected_chars.pop_front();
               if (rsp.out_char !== want.code) begin
                  $display("%0t: out_char mismatch: expected %h, actual %h",
                           $time, want.code, rsp.out_char);
                  errors_seen++;
               end
               if (rsp.out_last !== want.last) begin
                  $display("%0t: out_last mismatch: expected %b, actual %b",
                           $time, want.last, rsp.out_last);
                  errors_seen++;
               end
            end
         end
         if (req.valid && req.ready) begin
            encode_byte(req.data_byte, req.final_byte);
         end
      end
      chars_pending <= expected_chars.size();
   end

endmodule

>>> tb/base64_stream_encoder_tb.sv
// ----------------------------------------------------------------------------
// base64_stream_encoder_tb
// Drives messages of raw bytes into the base64 stream encoder, with random
// gaps on requests and random stalls on characters, and leaves the checking
// of every encoded character to base64_char_checker.
// ----------------------------------------------------------------------------
module base64_stream_encoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock;
   logic reset;
   logic steady;
   int   mismatch_count;
   int   chars_pending;

   b64e_req_if req_bus();
   b64e_rsp_if rsp_bus();

   base64_stream_encoder u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   base64_char_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req            (req_bus),
      .rsp            (rsp_bus),
      .mismatch_count (mismatch_count),
      .chars_pending  (chars_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #1ms;
      $display("base64_stream_encoder_tb: done, errors");
      $finish;
   end

   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= steady || ($urandom_range(0, 99) >= 25);
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic fin);
      while (!steady && $urandom_range(0, 99) < 25) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.data_byte  <= b;
      req_bus.final_byte <= fin;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // hold requests back until every predicted char has been taken
   task automatic drain_chars();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (chars_pending != 0) @(posedge clock);
   endtask

   initial begin
      int         n_sent;
      int         msg_len;
      logic [7:0] b;
      reset               = 1'b1;
      steady              <= 1'b0;
      req_bus.valid       <= 1'b0;
      req_bus.data_byte   <= 8'h00;
      req_bus.final_byte  <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // one-byte messages, flush with two pads
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      // two-byte messages, flush with one pad
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      // full group ending a message, all '+'
      send_byte(8'hFB, 1'b0);
      send_byte(8'hEF, 1'b0);
      send_byte(8'hBE, 1'b1);
      // two groups, all '_' then all 'A'
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte(8'h80, 1'b0);
      send_byte(8'h01, 1'b1);
      send_byte(8'h55, 1'b0);
      send_byte(8'hAA, 1'b1);
      drain_chars();

      n_sent = 0;
      while (n_sent < 300) begin
         msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24)
                                                : $urandom_range(1, 6);
         for (int i = 0; i < msg_len; i++) begin
            steady <= (n_sent >= 120 && n_sent < 200);
            case ($urandom_range(0, 7))
               0:       b = 8'h00;
               1:       b = 8'hFF;
               default: b = 8'($urandom);
            endcase
            send_byte(b, i == msg_len - 1);
            n_sent++;
         end
         if (n_sent >= 60 && n_sent < 70) begin
            drain_chars();
         end
      end

      steady <= 1'b0;
      drain_chars();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("base64_stream_encoder_tb: done, clean");
      end else begin
         $display("base64_stream_encoder_tb: done, errors");
      end
      $finish;
   end

endmodule

>>> filelist.f
hdl/b64e_pkg.sv
hdl/b64e_stream_if.sv
hdl/b64e_encode.sv
hdl/base64_stream_encoder.sv
tb/base64_char_checker.sv
tb/base64_stream_encoder_tb.sv
